/* design/clbp_pkg.sv */
// Shared constants, types and neighbour-offset functions for the circular LBP stream unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package clbp_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_RADIUS    = 3;

	// Fixed field and register widths.
	localparam int PIX_W        = 8;
	localparam int CODE_W       = 8;
	localparam int NUM_NB       = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int MAX_HEIGHT   = 4096;
	localparam int ROW_W        = 12;
	localparam int CMP_W        = 16;

	// Register values after reset.
	localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = HEIGHT_REG_W'(480);

	// Q8 fixed point: one pixel step is 256.
	localparam int Q8_ONE = 256;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	// Diagonal offset is radius * sqrt(1/2), rounded to Q8.
	function automatic int diag_q8(input int radius);
		return (radius * 46341 + 128) >>> 8;
	endfunction

	// Horizontal Q8 offset of neighbour n (x grows to the right).
	function automatic int nb_off_x(input int radius, input int n);
		int full;
		int dg;
		full = radius * Q8_ONE;
		dg   = diag_q8(radius);
		case (n)
			0:       return full;
			1:       return dg;
			2:       return 0;
			3:       return -dg;
			4:       return -full;
			5:       return -dg;
			6:       return 0;
			default: return dg;
		endcase
	endfunction

	// Vertical Q8 offset of neighbour n (y grows downward).
	function automatic int nb_off_y(input int radius, input int n);
		int full;
		int dg;
		full = radius * Q8_ONE;
		dg   = diag_q8(radius);
		case (n)
			0:       return 0;
			1:       return -dg;
			2:       return -full;
			3:       return -dg;
			4:       return 0;
			5:       return dg;
			6:       return full;
			default: return dg;
		endcase
	endfunction

endpackage

/* design/circular_lbp_code_stream_unit.sv */
// Top level of the circular LBP stream unit: handshakes, counters, window and output register.
// Depends on clbp_pkg, clbp_line_buf and clbp_code_calc.
`timescale 1ns / 1ps

// The unit takes one gray pixel per clock in raster order as long as the output side takes
// items, and returns one 8-bit circular LBP code (radius RADIUS, eight bilinear neighbours)
// for every pixel whose centre lies at least RADIUS from each border; border pixels give
// no item. A code passes the input, window and output registers after the pixel that
// completes its window. The line store is one memory of MAX_WIDTH words of 2*RADIUS bytes
// with one read and one byte write per cycle, so it needs no clearing after reset. tlast
// marks the code of the last pixel of a frame. The user must write width and height through
// the configuration port only while the unit is idle; the unit itself does not enforce it.
module circular_lbp_code_stream_unit #(
	parameter int MAX_WIDTH = clbp_pkg::DEF_MAX_WIDTH,
	parameter int RADIUS    = clbp_pkg::DEF_RADIUS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Pixel input.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [clbp_pkg::PIX_W-1:0]        s_tdata,    // [7:0] pixel
	// Code output.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [clbp_pkg::CODE_W-1:0]       m_tdata,    // [7:0] lbp_code
	output logic                              m_tlast,    // frame_last
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  clbp_pkg::cfg_idx_t                cfg_index,
	input  logic [clbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int WIN   = 2 * RADIUS + 1;
	localparam int LINES = 2 * RADIUS;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int SEL_W = $clog2(LINES);
	localparam int SW1   = SEL_W + 1;
	localparam int CW    = clbp_pkg::CMP_W;
	localparam int ROW_W = clbp_pkg::ROW_W;
	localparam int PW    = clbp_pkg::PIX_W;

	logic [clbp_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [clbp_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]                  col_q;
	logic [ROW_W-1:0]                  row_q;
	logic [SEL_W-1:0]                  sel_q;

	logic [CW-1:0]    w_raw, w_eff, h_raw, h_eff;
	logic [COL_W-1:0] c_cur;
	logic [ROW_W-1:0] r_cur;
	logic [SEL_W-1:0] sel_cur;
	logic             end_row, end_frame, emit;
	logic             accept;

	logic                        valid_s1, emit_s1, last_s1;
	logic [PW-1:0]               px_s1;
	logic [SEL_W-1:0]            sel_s1;
	logic [LINES-1:0][PW-1:0]    rd_s1;
	logic [WIN-1:0][PW-1:0]      col_new;

	logic                             valid_s2, last_s2;
	logic [WIN-1:0][WIN-1:0][PW-1:0]  window_q;
	logic [clbp_pkg::CODE_W-1:0]      code;

	logic                             out_valid_q, out_last_q;
	logic [clbp_pkg::CODE_W-1:0]      out_code_q;
	logic                             out_free, s2_free, adv1, adv2;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clbp_pkg::RESET_WIDTH;
			height_q <= clbp_pkg::RESET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				clbp_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= cfg_data[clbp_pkg::WIDTH_REG_W-1:0];
				end
				clbp_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[clbp_pkg::HEIGHT_REG_W-1:0];
				end
			endcase
		end
	end

	// Clamp the frame size to what the window and the line store allow.
	always_comb begin
		w_raw = CW'(width_q);
		h_raw = CW'(height_q);
		priority if (w_raw < CW'(WIN)) begin
			w_eff = CW'(WIN);
		end else if (w_raw > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		priority if (h_raw < CW'(WIN)) begin
			h_eff = CW'(WIN);
		end else if (h_raw > CW'(clbp_pkg::MAX_HEIGHT)) begin
			h_eff = CW'(clbp_pkg::MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
	end

	// Position of the incoming pixel; counters left past a smaller size restart at zero.
	always_comb begin
		c_cur = (CW'(col_q) >= w_eff) ? '0 : col_q;
		if (CW'(row_q) >= h_eff) begin
			r_cur   = '0;
			sel_cur = '0;
		end else begin
			r_cur   = row_q;
			sel_cur = sel_q;
		end
		end_row   = (CW'(c_cur) + CW'(1)) >= w_eff;
		end_frame = (CW'(r_cur) + CW'(1)) >= h_eff;
		emit      = (CW'(r_cur) >= CW'(LINES)) && (CW'(c_cur) >= CW'(LINES));
	end

	// Pipeline flow: each stage moves when the one after it is empty or moving.
	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	assign adv2     = valid_s2 && out_free;
	assign adv1     = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign accept   = s_tvalid && s_tready;

	// Column, row and line-slot counters advance with every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sel_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				if (end_frame) begin
					row_q <= '0;
					sel_q <= '0;
				end else begin
					row_q <= r_cur + ROW_W'(1);
					sel_q <= (sel_cur == SEL_W'(LINES - 1)) ? '0 : sel_cur + SEL_W'(1);
				end
			end else begin
				col_q <= c_cur + COL_W'(1);
			end
		end
	end

	// Line store: read the column for the window, store the new pixel in its line slot.
	clbp_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.LINES     (LINES)
	) u_line_buf (
		.clk        (clk),
		.access     (accept),
		.addr       (c_cur),
		.wr_slot    (sel_cur),
		.wr_data    (s_tdata),
		.rd_data_s1 (rd_s1)
	);

	// Input stage: the pixel and its flags wait here beside the line-store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_tdata;
			sel_s1  <= sel_cur;
			emit_s1 <= emit;
			last_s1 <= end_row && end_frame;
		end
	end

	// Order the buffered lines oldest first, the new pixel at the bottom.
	always_comb begin
		logic [SEL_W:0] rot;
		rot = '0;
		for (int i = 0; i < LINES; i++) begin
			rot = {1'b0, sel_s1} + SW1'(i);
			if (rot >= SW1'(LINES)) begin
				rot = rot - SW1'(LINES);
			end
			col_new[i] = rd_s1[rot[SEL_W-1:0]];
		end
		col_new[WIN-1] = px_s1;
	end

	// Window stage: shift left by one column for every item.
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < WIN; i++) begin
				for (int j = 0; j < WIN - 1; j++) begin
					window_q[i][j] <= window_q[i][j+1];
				end
				window_q[i][WIN-1] <= col_new[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= emit_s1;
		end else if (adv2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			last_s2 <= last_s1;
		end
	end

	clbp_code_calc #(
		.RADIUS (RADIUS)
	) u_code_calc (
		.window (window_q),
		.code   (code)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_code_q <= code;
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_code_q;
	assign m_tlast  = out_last_q;

endmodule

/* design/clbp_line_buf.sv */
// Line store of the circular LBP unit: one word per column holding a byte for each buffered line.
// Depends on clbp_pkg for the pixel width.
`timescale 1ns / 1ps

module clbp_line_buf #(
	parameter int MAX_WIDTH = clbp_pkg::DEF_MAX_WIDTH,
	parameter int LINES     = 2 * clbp_pkg::DEF_RADIUS
) (
	input  logic                                           clk,
	input  logic                                           access,
	input  logic [$clog2(MAX_WIDTH)-1:0]                   addr,
	input  logic [$clog2(LINES)-1:0]                       wr_slot,
	input  logic [clbp_pkg::PIX_W-1:0]                     wr_data,
	output logic [LINES-1:0][clbp_pkg::PIX_W-1:0]          rd_data_s1
);

	logic [LINES-1:0][clbp_pkg::PIX_W-1:0] mem [MAX_WIDTH];

	// Read the whole column word and replace one byte in the same cycle.
	// The read returns the contents from before this write.
	always_ff @(posedge clk) begin
		if (access) begin
			rd_data_s1             <= mem[addr];
			mem[addr][wr_slot]     <= wr_data;
		end
	end

endmodule

/* design/clbp_code_calc.sv */
// Combinational LBP code of one window: eight bilinear neighbours compared with the centre.
// Depends on clbp_pkg for widths and the neighbour offset functions.
`timescale 1ns / 1ps

module clbp_code_calc #(
	parameter int RADIUS = clbp_pkg::DEF_RADIUS
) (
	input  logic [2*RADIUS:0][2*RADIUS:0][clbp_pkg::PIX_W-1:0] window,
	output logic [clbp_pkg::CODE_W-1:0]                         code
);

	localparam int SUM_W = clbp_pkg::PIX_W + 16;

	logic [clbp_pkg::PIX_W-1:0] centre;
	assign centre = window[RADIUS][RADIUS];

	for (genvar n = 0; n < clbp_pkg::NUM_NB; n++) begin : g_nb
		// Split the Q8 offsets into window index and fraction at elaboration.
		localparam int VX  = clbp_pkg::nb_off_x(RADIUS, n);
		localparam int VY  = clbp_pkg::nb_off_y(RADIUS, n);
		localparam int BX  = VX + 16 * clbp_pkg::Q8_ONE;
		localparam int BY  = VY + 16 * clbp_pkg::Q8_ONE;
		localparam int FX  = BX / 256 - 16 + RADIUS;
		localparam int FY  = BY / 256 - 16 + RADIUS;
		localparam int TX  = BX % 256;
		localparam int TY  = BY % 256;
		localparam int CX  = (TX != 0) ? FX + 1 : FX;
		localparam int CY  = (TY != 0) ? FY + 1 : FY;
		localparam int W00 = (256 - TX) * (256 - TY);
		localparam int W01 = TX * (256 - TY);
		localparam int W10 = (256 - TX) * TY;
		localparam int W11 = TX * TY;

		logic [SUM_W-1:0] sum;

		// Exact weighted sum in Q16; the weights add up to one.
		assign sum = SUM_W'(W00) * SUM_W'(window[FY][FX])
			+ SUM_W'(W01) * SUM_W'(window[FY][CX])
			+ SUM_W'(W10) * SUM_W'(window[CY][FX])
			+ SUM_W'(W11) * SUM_W'(window[CY][CX]);

		assign code[n] = sum > {centre, 16'h0000};
	end

endmodule

/* design/clbp_checker.sv */
// Port-level checks for the circular LBP stream unit, bound to its top level.
// Depends on clbp_pkg and circular_lbp_code_stream_unit.
`timescale 1ns / 1ps

module clbp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [clbp_pkg::PIX_W-1:0]      s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [clbp_pkg::CODE_W-1:0]     m_tdata,
	input logic                            m_tlast,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input clbp_pkg::cfg_idx_t              cfg_index,
	input logic [clbp_pkg::CFG_DATA_W-1:0] cfg_data
);

	// A 7x7 frame is the smallest, so no code can appear before 49 pixels.
	localparam logic [5:0] MIN_PIXELS = 6'd49;

	logic [5:0] seen_q;

	// Saturating count of accepted pixels since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (s_tvalid && s_tready && seen_q != MIN_PIXELS) begin
			seen_q <= seen_q + 6'd1;
		end
	end

	// A stalled item stays put with its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// With the output register empty the unit must take a pixel.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled although the output side is empty");

	// No code before a full window of lines has arrived.
	a_no_early_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_q == MIN_PIXELS)
		else $error("code produced before the first window was filled");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind circular_lbp_code_stream_unit clbp_checker u_clbp_checker (.*);

/* tb/clbp_code_checker.sv */
// Checker for the circular LBP stream unit: watches the pixel, code and configuration channels.
// Predicts every code from the accepted pixels and compares it; depends on clbp_pkg.
`timescale 1ns / 1ps

module clbp_code_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [clbp_pkg::PIX_W-1:0]      s_tdata,    // [7:0] pixel
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [clbp_pkg::CODE_W-1:0]     m_tdata,    // [7:0] lbp_code
	input  logic                            m_tlast,    // frame_last
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  clbp_pkg::cfg_idx_t              cfg_index,
	input  logic [clbp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              codes_owed
);

	import clbp_pkg::*;

	localparam int RING_R = DEF_RADIUS;
	localparam int SPAN   = 2 * RING_R + 1;
	localparam int NLINES = 2 * RING_R;
	localparam int LINE_W = DEF_MAX_WIDTH;
	localparam int FULL   = RING_R * Q8_ONE;
	localparam int DIAG   = (RING_R * 46341 + 128) >>> 8;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} code_item_t;

	code_item_t              owed_q[$];
	code_item_t              want;
	logic [PIX_W-1:0]        line_mem [NLINES][LINE_W];
	logic [PIX_W-1:0]        window [SPAN][SPAN];
	int unsigned             col_pos;
	int unsigned             row_pos;
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	int                      bad_count;

	// Q8 position of ring point n relative to the centre; y grows downward.
	function automatic void ring_offset(input int n, output int dx, output int dy);
		case (n)
			0:       begin dx = FULL;  dy = 0;     end
			1:       begin dx = DIAG;  dy = -DIAG; end
			2:       begin dx = 0;     dy = -FULL; end
			3:       begin dx = -DIAG; dy = -DIAG; end
			4:       begin dx = -FULL; dy = 0;     end
			5:       begin dx = -DIAG; dy = DIAG;  end
			6:       begin dx = 0;     dy = FULL;  end
			default: begin dx = DIAG;  dy = DIAG;  end
		endcase
	endfunction

	// Code of the current window: each ring point is blended from its four
	// nearest pixels with Q16 weights and compared exactly with the centre.
	function automatic logic [CODE_W-1:0] ring_code();
		int                n;
		int                dx, dy, ix, iy, fx, fy, cx, cy;
		longint            acc;
		longint            centre;
		logic [CODE_W-1:0] code;
		code   = '0;
		centre = longint'(window[RING_R][RING_R]) << 16;
		for (n = 0; n < NUM_NB; n++) begin
			ring_offset(n, dx, dy);
			ix  = (dx >>> 8) + RING_R;
			iy  = (dy >>> 8) + RING_R;
			fx  = dx & 255;
			fy  = dy & 255;
			cx  = ix + ((fx != 0) ? 1 : 0);
			cy  = iy + ((fy != 0) ? 1 : 0);
			acc = longint'((256 - fx) * (256 - fy)) * window[iy][ix]
				+ longint'(fx * (256 - fy)) * window[iy][cx]
				+ longint'((256 - fx) * fy) * window[cy][ix]
				+ longint'(fx * fy) * window[cy][cx];
			if (acc > centre)
				code[n] = 1'b1;
		end
		return code;
	endfunction

	// One pixel through the line store and window; queues a code away from the border.
	task automatic take_pixel(input logic [PIX_W-1:0] px);
		int unsigned w, h, r, c;
		int          i, j;
		code_item_t  item;
		w = width_reg;
		h = height_reg;
		if (w < SPAN) w = SPAN;
		if (w > LINE_W) w = LINE_W;
		if (h < SPAN) h = SPAN;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		r = row_pos;
		c = col_pos;

		for (i = 0; i < SPAN; i++)
			for (j = 0; j < SPAN - 1; j++)
				window[i][j] = window[i][j + 1];
		for (i = 0; i < NLINES; i++)
			window[i][SPAN - 1] = line_mem[(r + i) % NLINES][c];
		window[SPAN - 1][SPAN - 1] = px;
		line_mem[r % NLINES][c]    = px;

		if (r >= NLINES && c >= NLINES) begin
			item.code = ring_code();
			item.last = (r == h - 1 && c == w - 1);
			owed_q.push_back(item);
		end

		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// Compare outgoing codes first; a pixel taken at the same edge cannot have left yet.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			for (int i = 0; i < SPAN; i++)
				for (int j = 0; j < SPAN; j++)
					window[i][j] = '0;
			col_pos    = 0;
			row_pos    = 0;
			width_reg  = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			bad_count  = 0;
			mismatches <= 0;
			codes_owed <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_q.size() == 0) begin
					$error("code item 0x%02h arrived with nothing expected", m_tdata);
					bad_count++;
				end else begin
					want = owed_q.pop_front();
					if (m_tdata !== want.code) begin
						$error("lbp_code mismatch: expected 0x%02h, got 0x%02h", want.code,
							m_tdata);
						bad_count++;
					end
					if (m_tlast !== want.last) begin
						$error("frame_last mismatch: expected %0b, got %0b", want.last,
							m_tlast);
						bad_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_REG_W-1:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
					default:          ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_pixel(s_tdata);
			mismatches <= bad_count;
			codes_owed <= owed_q.size();
		end
	end

endmodule

/* tb/circular_lbp_code_stream_unit_test.sv */
// Testbench top for the circular LBP stream unit: clock, reset, pixel frames and size writes.
// Depends on clbp_pkg, the unit itself and clbp_code_checker, which predicts and compares.
`timescale 1ns / 1ps

module circular_lbp_code_stream_unit_test;

	import clbp_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1250;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [CODE_W-1:0]     m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	int                    mismatches;
	int                    codes_owed;

	// Stimulus-side view of the geometry and the raster position of the next pixel.
	int track_w = 640;
	int track_h = 480;
	int trk_col = 0;
	int trk_row = 0;
	int sent_total = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int frame_style = 0;
	int frame_base = 0;

	circular_lbp_code_stream_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	clbp_code_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.codes_owed (codes_owed)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall);
	end

	function automatic int eff_dim(input int raw, input int lo, input int hi);
		if (raw < lo) return lo;
		if (raw > hi) return hi;
		return raw;
	endfunction

	// Pixel content of a random frame, following the frame's texture style.
	function automatic logic [PIX_W-1:0] next_pixel();
		int v;
		case (frame_style)
			0: v = $urandom_range(0, 255);
			1: v = frame_base + int'($urandom_range(0, 8)) - 4;
			2: v = $urandom_range(0, 1) ? 255 : 0;
			default: v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255)) : frame_base;
		endcase
		return PIX_W'(eff_dim(v, 0, 255));
	endfunction

	// Directed frame: a dark centre in bright surroundings, then a mid-gray centre above
	// a striped pattern.
	function automatic logic [PIX_W-1:0] directed_pixel(input int r, input int c);
		if (r == 3 && c == 3) return 8'd0;
		if (r == 5 && c == 3) return 8'd128;
		if (r >= 7) return (c % 2) ? 8'd200 : 8'd100;
		return 8'd255;
	endfunction

	// The unit restarts a counter that lies past the current size.
	task automatic settle_pos();
		if (trk_col >= track_w) trk_col = 0;
		if (trk_row >= track_h) trk_row = 0;
	endtask

	// Hold the sender until every expected code has come, then let the pipeline empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (codes_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		if ($urandom_range(0, 499) == 0)
			drain();
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= px;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		settle_pos();
		if (trk_col + 1 >= track_w) begin
			trk_col = 0;
			trk_row = (trk_row + 1 >= track_h) ? 0 : trk_row + 1;
		end else begin
			trk_col++;
		end
		sent_total++;
	endtask

	// Both size registers are written back to back once the unit is idle.
	task automatic set_geometry(input logic [CFG_DATA_W-1:0] raw_w,
		input logic [CFG_DATA_W-1:0] raw_h);
		drain();
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= raw_w;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data  <= raw_h;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		track_w = eff_dim(int'(raw_w[WIDTH_REG_W-1:0]), 7, DEF_MAX_WIDTH);
		track_h = eff_dim(int'(raw_h), 7, MAX_HEIGHT);
	endtask

	task automatic set_pace(input int idle_pct, input int stall_pct);
		send_idle  = idle_pct;
		recv_stall = stall_pct;
	endtask

	// Run time limit, far above the slowest correct run.
	initial begin
		#3_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int                    frame_no;
		int                    start_count;
		int                    sel;
		int                    cut_len;
		logic [CFG_DATA_W-1:0] raw_w;
		logic [CFG_DATA_W-1:0] raw_h;
		bit                    cut;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few border pixels at the reset size, then a width below range while the
		// column counter is past it, then the directed frame of 7 by 9.
		set_pace(0, 0);
		repeat (10) send_pixel(PIX_W'($urandom_range(0, 255)));
		set_geometry('0, 13'd9);
		do begin
			settle_pos();
			send_pixel(directed_pixel(trk_row, trk_col));
		end while (trk_col != 0 || trk_row != 0);

		// Widest line: all width bits set, clamped to the maximum.
		set_pace(32, 32);
		set_geometry('1, 13'd7);
		frame_style = 0;
		repeat (track_w * track_h) send_pixel(next_pixel());

		// Tallest frame, cut short by a smaller height that sends the row counter home.
		set_pace(49, 0);
		set_geometry(13'd7, 13'd4096);
		frame_style = 1;
		frame_base  = 128;
		repeat (7 * 12) send_pixel(next_pixel());
		set_geometry(13'd7, 13'd8);
		do send_pixel(next_pixel()); while (trk_col != 0 || trk_row != 0);

		// Random frames, each starting at the top left corner.
		frame_no    = 0;
		start_count = sent_total;
		while (sent_total < start_count + RANDOM_ITEMS) begin
			case ((frame_no / 4) % 4)
				0: set_pace(0, 0);
				1: set_pace(49, 0);
				2: set_pace(0, 49);
				default: set_pace(32, 32);
			endcase
			sel = $urandom_range(0, 9);
			if (sel == 0) raw_w = $urandom_range(0, 6);
			else if (sel == 1) raw_w = $urandom_range(17, 40);
			else raw_w = $urandom_range(7, 16);
			sel = $urandom_range(0, 9);
			if (sel == 0) raw_h = $urandom_range(0, 6);
			else if (sel == 1) raw_h = $urandom_range(0, 1) ? 13'd4096 : $urandom_range(4097, 8191);
			else raw_h = $urandom_range(7, 12);
			set_geometry(raw_w, raw_h);
			frame_style = $urandom_range(0, 3);
			frame_base  = $urandom_range(0, 255);
			cut = (track_h > 12) || ($urandom_range(0, 3) == 0);
			if (cut) begin
				// Stop part way, shrink the size, and finish the frame as the unit sees it.
				cut_len = $urandom_range(1, track_w * eff_dim(track_h, 7, 12) - 1);
				repeat (cut_len) send_pixel(next_pixel());
				set_geometry($urandom_range(0, track_w), $urandom_range(0, 12));
				do send_pixel(next_pixel()); while (trk_col != 0 || trk_row != 0);
			end else begin
				repeat (track_w * track_h) send_pixel(next_pixel());
			end
			frame_no++;
		end

		drain();
		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
